[src/disk_seek_sort_queue_core_assert.svh]
// assertion macros used by the checker file
`ifndef DISK_SEEK_SORT_QUEUE_CORE_ASSERT_SVH
`define DISK_SEEK_SORT_QUEUE_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DSSQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DSSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/dssq_pkg.sv]
`timescale 1ns / 1ps

package dssq_pkg;

    // field widths
    localparam int TAG_W = 8;
    localparam int CYL_W = 16;
    localparam int PLACED_W = 4;
    localparam int COUNT_W = 5;

    // default number of queue slots
    localparam int QUEUE_DEPTH_DEFAULT = 16;

    // read flag value
    localparam logic B_READ = 1'b1;

    // request actions
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef struct packed {
        logic             action;
        logic [TAG_W-1:0] request_tag;
        logic [CYL_W-1:0] request_cylinder;
        logic             request_is_read;
    } t_req;

    typedef struct packed {
        logic                accepted;
        logic [PLACED_W-1:0] placed_index;
        logic [TAG_W-1:0]    head_tag;
        logic [CYL_W-1:0]    head_cylinder;
        logic                head_is_read;
        logic [COUNT_W-1:0]  queue_count;
    } t_rsp;

    // one stored queue slot
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [CYL_W-1:0] cylinder;
        logic             is_read;
    } t_entry;

    // commit command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_op;

    // scan token flags passed from cell to cell
    typedef struct packed {
        logic valid;
        logic have;
        logic stop;
    } t_scan;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

endpackage

[src/disk_seek_sort_queue_core.sv]
`timescale 1ns / 1ps

// Seek-sorted disk request queue built as a row of QUEUE_DEPTH slot cells. A request is
// taken when start is high and busy is low; its single response appears on o_rsp for one
// cycle with o_rsp_valid high and cannot be held off, so it must be captured then. A remove,
// an insert into an empty queue and a rejected insert into a full queue go straight from
// acceptance to the commit state. An insert into a partly filled queue scans first:
// a scan token walks the cell row one slot per cycle, the placement taken from the last
// cell is latched into r_pos, then the commit state shifts the slots. busy drops in the cycle the
// response is shown, so a new request may be accepted alongside it. Slot contents are not
// cleared at reset; the fill count is.

module disk_seek_sort_queue_core #(
    parameter int QUEUE_DEPTH = dssq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  dssq_pkg::t_req i_req,
    output logic           busy,
    output logic           o_rsp_valid,
    output dssq_pkg::t_rsp o_rsp
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dssq_pkg::t_state  r_state, n_state;
    dssq_pkg::t_req    r_req;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic              r_tok0_valid;
    dssq_pkg::t_rsp    r_rsp, n_rsp;
    logic              r_rsp_valid;

    logic              w_accept;
    logic              w_commit;
    logic              w_ins_ok;
    logic              w_pop_ok;
    logic              w_full;
    logic              w_empty;
    dssq_pkg::t_cell_op w_op;
    dssq_pkg::t_entry  w_new;
    dssq_pkg::t_scan   w_tok0;
    logic [IDX_W+3:0]  w_pos_ext;
    logic [CNT_W+4:0]  w_cnt_ext;

    dssq_pkg::t_entry           w_entry   [QUEUE_DEPTH];
    dssq_pkg::t_scan            w_tok     [QUEUE_DEPTH];
    logic [IDX_W-1:0]           w_tok_idx [QUEUE_DEPTH];
    logic [dssq_pkg::CYL_W-1:0] w_tok_cyl [QUEUE_DEPTH];

    assign w_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_accept = start && (r_state == dssq_pkg::ST_IDLE);

    // new slot contents from the held request
    assign w_new.tag      = r_req.request_tag;
    assign w_new.cylinder = r_req.request_cylinder;
    assign w_new.is_read  = r_req.request_is_read;

    // scan token entering the first cell
    assign w_tok0.valid = r_tok0_valid;
    assign w_tok0.have  = 1'b0;
    assign w_tok0.stop  = 1'b0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dssq_pkg::ST_IDLE: begin
                if (start) begin
                    if ((i_req.action == dssq_pkg::ACT_INSERT) && !w_full && !w_empty) begin
                        n_state = dssq_pkg::ST_SCAN;
                    end else begin
                        n_state = dssq_pkg::ST_COMMIT;
                    end
                end
            end
            dssq_pkg::ST_SCAN: begin
                if (w_tok[QUEUE_DEPTH-1].valid) begin
                    n_state = dssq_pkg::ST_COMMIT;
                end
            end
            dssq_pkg::ST_COMMIT: begin
                n_state = dssq_pkg::ST_IDLE;
            end
            default: begin
                n_state = dssq_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        busy     = 1'b1;
        w_commit = 1'b0;
        unique case (r_state)
            dssq_pkg::ST_IDLE: begin
                busy = 1'b0;
            end
            dssq_pkg::ST_SCAN: begin
                busy = 1'b1;
            end
            dssq_pkg::ST_COMMIT: begin
                w_commit = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // commit decisions
    assign w_ins_ok  = (r_req.action == dssq_pkg::ACT_INSERT) && !w_full;
    assign w_pop_ok  = (r_req.action == dssq_pkg::ACT_REMOVE) && !w_empty;
    assign w_op.insert = w_commit && w_ins_ok;
    assign w_op.pop    = w_commit && w_pop_ok;

    // placement: after the chosen slot, else at the tail
    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            n_pos = '0;
        end else if ((r_state == dssq_pkg::ST_SCAN) && w_tok[QUEUE_DEPTH-1].valid) begin
            if (w_tok[QUEUE_DEPTH-1].have) begin
                n_pos = w_tok_idx[QUEUE_DEPTH-1] + 1'b1;
            end else begin
                n_pos = r_count[IDX_W-1:0];
            end
        end
    end

    // fill count after the step
    always_comb begin
        n_count = r_count;
        if (w_op.insert) begin
            n_count = r_count + 1'b1;
        end else if (w_op.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    assign w_pos_ext = {4'b0, r_pos};
    assign w_cnt_ext = {5'b0, n_count};

    // response contents
    always_comb begin
        n_rsp               = '0;
        n_rsp.accepted      = w_ins_ok || w_pop_ok;
        n_rsp.queue_count   = w_cnt_ext[dssq_pkg::COUNT_W-1:0];
        if (w_ins_ok) begin
            n_rsp.placed_index = w_pos_ext[dssq_pkg::PLACED_W-1:0];
        end
        if (w_pop_ok) begin
            n_rsp.head_tag      = w_entry[0].tag;
            n_rsp.head_cylinder = w_entry[0].cylinder;
            n_rsp.head_is_read  = w_entry[0].is_read;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dssq_pkg::ST_IDLE;
            r_count      <= '0;
            r_tok0_valid <= 1'b0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_tok0_valid <= w_accept && (i_req.action == dssq_pkg::ACT_INSERT) &&
                            !w_full && !w_empty;
            r_rsp_valid  <= w_commit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        if (w_commit) begin
            r_rsp <= n_rsp;
        end
        r_pos <= n_pos;
    end

    // row of slot cells
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            dssq_pkg::t_entry           w_left;
            dssq_pkg::t_entry           w_right;
            dssq_pkg::t_scan            w_tin;
            logic [IDX_W-1:0]           w_tin_idx;
            logic [dssq_pkg::CYL_W-1:0] w_tin_cyl;

            if (g == 0) begin : g_first
                assign w_left    = w_new;
                assign w_tin     = w_tok0;
                assign w_tin_idx = '0;
                assign w_tin_cyl = '0;
            end else begin : g_mid
                assign w_left    = w_entry[g-1];
                assign w_tin     = w_tok[g-1];
                assign w_tin_idx = w_tok_idx[g-1];
                assign w_tin_cyl = w_tok_cyl[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_right = w_entry[g];
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end

            dssq_cell #(
                .QUEUE_DEPTH(QUEUE_DEPTH),
                .CELL_INDEX (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_op      (w_op),
                .i_pos     (r_pos),
                .i_count   (r_count),
                .i_new     (w_new),
                .i_left    (w_left),
                .i_right   (w_right),
                .i_tok     (w_tin),
                .i_tok_idx (w_tin_idx),
                .i_tok_cyl (w_tin_cyl),
                .o_tok     (w_tok[g]),
                .o_tok_idx (w_tok_idx[g]),
                .o_tok_cyl (w_tok_cyl[g]),
                .o_entry   (w_entry[g])
            );
        end
    endgenerate

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

[src/dssq_cell.sv]
`timescale 1ns / 1ps

module dssq_cell #(
    parameter int QUEUE_DEPTH = dssq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int CELL_INDEX  = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dssq_pkg::t_cell_op          i_op,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]   i_pos,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] i_count,
    input  dssq_pkg::t_entry            i_new,
    input  dssq_pkg::t_entry            i_left,
    input  dssq_pkg::t_entry            i_right,
    input  dssq_pkg::t_scan             i_tok,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]   i_tok_idx,
    input  logic [dssq_pkg::CYL_W-1:0]  i_tok_cyl,
    output dssq_pkg::t_scan             o_tok,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   o_tok_idx,
    output logic [dssq_pkg::CYL_W-1:0]  o_tok_cyl,
    output dssq_pkg::t_entry            o_entry
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);

    dssq_pkg::t_entry          r_entry, n_entry;
    dssq_pkg::t_scan           r_tok, n_tok;
    logic [IDX_W-1:0]          r_tok_idx, n_tok_idx;
    logic [dssq_pkg::CYL_W-1:0] r_tok_cyl, n_tok_cyl;

    logic w_in_range;
    logic w_active;
    logic w_req_rd;
    logic w_ent_rd;

    assign w_in_range = (i_count > MY_CNT);
    assign w_active   = i_tok.valid && !i_tok.stop && w_in_range;
    assign w_req_rd   = (i_new.is_read == dssq_pkg::B_READ);
    assign w_ent_rd   = (r_entry.is_read == dssq_pkg::B_READ);

    // scan step: fold this slot into the travelling choice
    always_comb begin
        n_tok     = i_tok;
        n_tok_idx = i_tok_idx;
        n_tok_cyl = i_tok_cyl;
        if (w_active) begin
            if (w_req_rd && !w_ent_rd) begin
                // a read stops at the first write
                n_tok.stop = 1'b1;
                if (!i_tok.have) begin
                    n_tok.have = 1'b1;
                    n_tok_idx  = MY_IDX;
                    n_tok_cyl  = r_entry.cylinder;
                end
            end else if (w_req_rd == w_ent_rd) begin
                // same class: highest cylinder at or below, later slot wins a tie
                if ((r_entry.cylinder <= i_new.cylinder) &&
                    (!i_tok.have || (r_entry.cylinder >= i_tok_cyl))) begin
                    n_tok.have = 1'b1;
                    n_tok_idx  = MY_IDX;
                    n_tok_cyl  = r_entry.cylinder;
                end
            end
        end
    end

    // slot update on commit
    always_comb begin
        n_entry = r_entry;
        if (i_op.pop) begin
            n_entry = i_right;
        end else if (i_op.insert) begin
            if (MY_IDX == i_pos) begin
                n_entry = i_new;
            end else if ((MY_IDX > i_pos) && (MY_CNT <= i_count)) begin
                n_entry = i_left;
            end
        end
    end

    // token flags are control, the rest is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry   <= n_entry;
        r_tok_idx <= n_tok_idx;
        r_tok_cyl <= n_tok_cyl;
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;
    assign o_tok_cyl = r_tok_cyl;
    assign o_entry   = r_entry;

endmodule

[src/dssq_checker.sv]
`timescale 1ns / 1ps

`include "disk_seek_sort_queue_core_assert.svh"

module dssq_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_rsp_valid,
    input dssq_pkg::t_rsp o_rsp
);

    // an accepted request keeps the block busy in the next cycle
    `DSSQ_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "request not held")

    // no response in the cycle right after a request is taken
    `DSSQ_ASSERT_NEXT(a_no_early_rsp, i_clk, i_rst_n, start && !busy, !o_rsp_valid, "early response")

    // response is shown only once the block is free again
    `DSSQ_ASSERT_SAME(a_rsp_idle, i_clk, i_rst_n, o_rsp_valid, !busy, "response while busy")

    // a refused request reports no placement and no head
    `DSSQ_ASSERT_SAME(a_reject_clean, i_clk, i_rst_n, o_rsp_valid && !o_rsp.accepted, (o_rsp.placed_index == '0) && (o_rsp.head_tag == '0) && (o_rsp.head_cylinder == '0) && (o_rsp.head_is_read == 1'b0), "refused response not clean")

endmodule

bind disk_seek_sort_queue_core dssq_checker u_dssq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import dssq_pkg::*;

    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT;
    localparam int CLK_HALF    = 4;
    localparam int RAND_REQS   = 1850;
    // a seek-sorted insert scans the whole cell row, then commits
    localparam int SETTLE_CYC  = QUEUE_DEPTH + 6;

    // one request waiting to be driven, with its idle time ahead of it
    typedef struct {
        t_req req;
        int   gap;
        bit   drain;
    } t_pending_req;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_rsp_valid;
    t_rsp o_rsp;

    // request stream and expected responses
    t_pending_req pending_reqs[$];
    t_rsp         expected_rsps[$];
    int           reqs_total;
    int           reqs_taken = 0;
    int           fail_count = 0;

    // driver and monitor hand-over
    bit           took_req   = 1'b0;
    bit           req_staged = 1'b0;
    t_pending_req staged_req;
    int           hold_cycles = 0;

    // shadow of the seek-sorted queue
    t_entry slot_model [QUEUE_DEPTH];
    int     slot_fill = 0;

    disk_seek_sort_queue_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_rsp_valid(o_rsp_valid),
        .o_rsp      (o_rsp)
    );

    // clock
    always #(CLK_HALF) i_clk = ~i_clk;

    // apply one request to the shadow queue and return its response
    function automatic t_rsp seek_sort_apply(t_req rq);
        t_rsp rs;
        int   pos;
        int   chosen;
        bit   have;
        bit   rq_read;
        bit   slot_read;
        rs = '0;
        rq_read = (rq.request_is_read == B_READ);
        if (rq.action == ACT_INSERT) begin
            if (slot_fill < QUEUE_DEPTH) begin
                pos = 0;
                if (slot_fill != 0) begin
                    have = 1'b0;
                    chosen = 0;
                    // elevator scan from the head
                    for (int i = 0; i < slot_fill; i++) begin
                        slot_read = (slot_model[i].is_read == B_READ);
                        if (rq_read && !slot_read) begin
                            if (!have) begin
                                have = 1'b1;
                                chosen = i;
                            end
                            break;
                        end
                        if (!rq_read && slot_read)
                            continue;
                        if (slot_model[i].cylinder <= rq.request_cylinder &&
                            (!have || slot_model[i].cylinder >= slot_model[chosen].cylinder))
                        begin
                            have = 1'b1;
                            chosen = i;
                        end
                    end
                    pos = have ? chosen + 1 : slot_fill;
                end
                for (int i = slot_fill; i > pos; i--)
                    slot_model[i] = slot_model[i-1];
                slot_model[pos].tag      = rq.request_tag;
                slot_model[pos].cylinder = rq.request_cylinder;
                slot_model[pos].is_read  = rq.request_is_read;
                slot_fill++;
                rs.accepted     = 1'b1;
                rs.placed_index = PLACED_W'(pos);
            end
        end else if (slot_fill != 0) begin
            rs.head_tag      = slot_model[0].tag;
            rs.head_cylinder = slot_model[0].cylinder;
            rs.head_is_read  = slot_model[0].is_read;
            for (int i = 1; i < slot_fill; i++)
                slot_model[i-1] = slot_model[i];
            slot_fill--;
            rs.accepted = 1'b1;
        end
        rs.queue_count = COUNT_W'(slot_fill);
        return rs;
    endfunction

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // clustered cylinders give ties, the rest spans the full range
    function automatic logic [CYL_W-1:0] pick_cylinder();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return CYL_W'($urandom_range(0, 15));
        if (r < 55)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return CYL_W'($urandom);
    endfunction

    function automatic void queue_req(logic act, logic [TAG_W-1:0] tag,
                                      logic [CYL_W-1:0] cyl, logic rd, int gap, bit drain);
        t_pending_req p;
        p.req.action           = act;
        p.req.request_tag      = tag;
        p.req.request_cylinder = cyl;
        p.req.request_is_read  = rd;
        p.gap   = gap;
        p.drain = drain;
        pending_reqs.push_back(p);
    endfunction

    // request driver, changes inputs on the falling edge
    always @(negedge i_clk) begin : req_driver
        logic drive_start;
        t_req drive_req;
        drive_start = start;
        drive_req   = i_req;
        if (start && took_req)
            drive_start = 1'b0;
        if (i_rst_n && !drive_start) begin
            if (!req_staged && pending_reqs.size() != 0) begin
                staged_req  = pending_reqs.pop_front();
                req_staged  = 1'b1;
                hold_cycles = staged_req.gap;
            end
            if (req_staged) begin
                if (hold_cycles > 0)
                    hold_cycles--;
                else if (!(staged_req.drain && expected_rsps.size() != 0)) begin
                    drive_start = 1'b1;
                    drive_req   = staged_req.req;
                    req_staged  = 1'b0;
                end
            end
        end
        start <= drive_start;
        i_req <= drive_req;
    end

    // response checker and request capture on the rising edge
    always @(posedge i_clk) begin : rsp_monitor
        t_rsp want;
        took_req = 1'b0;
        if (i_rst_n) begin
            // a response always belongs to an earlier request
            if (o_rsp_valid) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected response %h", o_rsp);
                    fail_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (o_rsp.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d",
                               want.accepted, o_rsp.accepted);
                        fail_count++;
                    end
                    if (o_rsp.placed_index !== want.placed_index) begin
                        $error("placed_index: expected %0d, got %0d",
                               want.placed_index, o_rsp.placed_index);
                        fail_count++;
                    end
                    if (o_rsp.head_tag !== want.head_tag) begin
                        $error("head_tag: expected %0d, got %0d",
                               want.head_tag, o_rsp.head_tag);
                        fail_count++;
                    end
                    if (o_rsp.head_cylinder !== want.head_cylinder) begin
                        $error("head_cylinder: expected %0d, got %0d",
                               want.head_cylinder, o_rsp.head_cylinder);
                        fail_count++;
                    end
                    if (o_rsp.head_is_read !== want.head_is_read) begin
                        $error("head_is_read: expected %0d, got %0d",
                               want.head_is_read, o_rsp.head_is_read);
                        fail_count++;
                    end
                    if (o_rsp.queue_count !== want.queue_count) begin
                        $error("queue_count: expected %0d, got %0d",
                               want.queue_count, o_rsp.queue_count);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                took_req = 1'b1;
                expected_rsps.push_back(seek_sort_apply(i_req));
                reqs_taken++;
            end
        end
    end

    // overall time limit
    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus and end of run
    initial begin : stim_main
        int  insert_pct;
        int  burst_left;
        bit  quiet;
        logic act;

        // directed: empty remove, ties, class boundaries, extremes
        queue_req(ACT_REMOVE, 8'hFF, 16'hFFFF, 1'b1, 0, 1'b0);
        queue_req(ACT_INSERT, 8'h01, 16'd100, B_READ, 0, 1'b0);
        queue_req(ACT_INSERT, 8'h00, 16'd0, ~B_READ, 1, 1'b0);
        queue_req(ACT_INSERT, 8'hFF, 16'hFFFF, ~B_READ, 0, 1'b0);
        queue_req(ACT_INSERT, 8'h02, 16'd100, B_READ, 2, 1'b0);
        queue_req(ACT_INSERT, 8'h03, 16'd50, B_READ, 0, 1'b0);
        queue_req(ACT_INSERT, 8'h04, 16'd0, ~B_READ, 0, 1'b0);
        queue_req(ACT_INSERT, 8'h05, 16'hFFFF, B_READ, 5, 1'b0);
        queue_req(ACT_INSERT, 8'h06, 16'd300, ~B_READ, 0, 1'b0);
        // fill to the top, then one insert too many
        for (int i = 0; i < QUEUE_DEPTH - 8; i++)
            queue_req(ACT_INSERT, TAG_W'($urandom), pick_cylinder(), 1'($urandom_range(0, 1)),
                      pick_gap(1'b0), 1'b0);
        queue_req(ACT_INSERT, 8'hAA, 16'h5555, B_READ, 0, 1'b1);
        queue_req(ACT_REMOVE, 8'h00, 16'h0000, 1'b0, 0, 1'b0);
        queue_req(ACT_REMOVE, 8'h55, 16'hAAAA, 1'b1, 3, 1'b0);

        // random bursts that lean towards filling, draining or neither
        burst_left = 0;
        insert_pct = 50;
        quiet = 1'b0;
        for (int n = 0; n < RAND_REQS; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 20;
                    default: insert_pct = 50;
                endcase
                quiet = ($urandom_range(0, 3) == 0);
            end
            burst_left--;
            act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
            queue_req(act, TAG_W'($urandom), pick_cylinder(), 1'($urandom_range(0, 1)),
                      pick_gap(quiet), (n % 300) == 150);
        end
        reqs_total = pending_reqs.size();

        // reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (reqs_taken < reqs_total || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/dssq_pkg.sv
src/dssq_cell.sv
src/disk_seek_sort_queue_core.sv
src/dssq_checker.sv
tb/sv/testbench.sv
